>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LISR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define LISR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/lisr_pkg.sv
// Types and constants shared by the linear interpolation resampler.
package lisr_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned POS_W     = 25;
  localparam int unsigned CUR_W     = POS_W - FRAC_BITS;

  localparam logic [15:0] U8_SILENCE  = 16'h0080;
  localparam logic [15:0] S16_SILENCE = 16'h0000;

  localparam logic [2:0] CFG_STEP_SIZE     = 3'd0;
  localparam logic [2:0] CFG_FRAME_COUNT   = 3'd1;
  localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_FORMAT = 3'd3;
  localparam logic [2:0] CFG_STEREO_MODE   = 3'd4;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_START   = 2'd1,
    ACT_PRODUCE = 2'd2
  } action_e;

  typedef struct packed {
    logic [15:0] step_size;
    logic [16:0] frame_count;
    logic        loop_enable;
    logic        sample_format;
    logic        stereo_mode;
  } cfg_t;

  // One produce request travelling alongside its store reads.
  typedef struct packed {
    logic                 valid;
    logic                 cur_ok;
    logic                 nxt_ok;
    logic [FRAC_BITS-1:0] frac;
    logic                 fin;
  } rd_req_t;

endpackage

>>> hw/rtl/lisr_store.sv
// Sample store: one write port and two registered read ports.
module lisr_store import lisr_pkg::*; #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [31:0]   rdata_a_o,
  output logic [31:0]   rdata_b_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/lisr_ctrl.sv
// Play position, finished flag and store addressing for each request.
module lisr_ctrl import lisr_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 65536,
  parameter int unsigned AW         = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          fire_i,
  input  action_e       action_i,
  input  logic [15:0]   frame_index_i,
  input  cfg_t          cfg_i,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [AW-1:0] raddr_cur_o,
  output logic [AW-1:0] raddr_nxt_o,
  output rd_req_t       req_o,
  output logic          done_o
);

  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 done_q, done_d;
  rd_req_t              req_q, req_d;
  logic [16:0]          fc_sat;
  logic [16:0]          frames;
  logic [POS_W-1:0]     pos_end;
  logic [POS_W-1:0]     pos_last;
  logic [POS_W-1:0]     pos_sum;
  logic [CUR_W-1:0]     cur;
  logic [CUR_W:0]       nxt;
  logic [31:0]          cur32, nxt32, idx32;
  logic                 cur_ok, nxt_ok;

  always_comb begin
    priority if (cfg_i.frame_count == 17'd0) begin
      fc_sat = 17'd1;
    end else if (cfg_i.frame_count > 17'd65536) begin
      fc_sat = 17'd65536;
    end else begin
      fc_sat = cfg_i.frame_count;
    end
    frames   = (32'(fc_sat) > 32'(MAX_FRAMES)) ? 17'(MAX_FRAMES) : fc_sat;
    pos_end  = {frames, {FRAC_BITS{1'b0}}};
    pos_last = {frames - 17'd1, {FRAC_BITS{1'b0}}};
  end

  assign cur     = pos_q[POS_W-1:FRAC_BITS];
  assign nxt     = {1'b0, cur} + {{CUR_W{1'b0}}, 1'b1};
  assign cur32   = 32'(cur);
  assign nxt32   = 32'(nxt);
  assign idx32   = 32'(frame_index_i);
  assign cur_ok  = cur32 < 32'(MAX_FRAMES);
  // The next frame exists only inside the sound and inside the store.
  assign nxt_ok  = (pos_q < pos_last) && (nxt32 < 32'(MAX_FRAMES));
  assign pos_sum = pos_q + POS_W'(cfg_i.step_size);

  always_comb begin
    pos_d  = pos_q;
    done_d = done_q;
    req_d  = '0;
    we_o   = 1'b0;
    if (fire_i) begin
      unique case (action_i)
        ACT_LOAD: begin
          we_o = idx32 < 32'(MAX_FRAMES);
        end
        ACT_START: begin
          pos_d  = '0;
          done_d = 1'b0;
        end
        ACT_PRODUCE: begin
          if (!done_q) begin
            req_d.valid  = 1'b1;
            req_d.cur_ok = cur_ok;
            req_d.nxt_ok = nxt_ok;
            req_d.frac   = pos_q[FRAC_BITS-1:0];
            pos_d        = pos_sum;
            if (pos_sum >= pos_end) begin
              if (cfg_i.loop_enable) begin
                pos_d = '0;
              end else begin
                done_d    = 1'b1;
                req_d.fin = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
      req_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
      if (adv_i) begin
        req_q <= req_d;
      end
    end
  end

  assign waddr_o     = idx32[AW-1:0];
  assign raddr_cur_o = cur32[AW-1:0];
  assign raddr_nxt_o = nxt32[AW-1:0];
  assign req_o       = req_q;
  assign done_o      = done_q;

endmodule

>>> hw/rtl/lisr_blend.sv
// Two-stage blend of current and next frame by the position fraction.
module lisr_blend import lisr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  rd_req_t     req_i,
  input  logic [31:0] cur_data_i,
  input  logic [31:0] nxt_data_i,
  input  logic        sample_format_i,
  input  logic        stereo_mode_i,
  output logic        valid_o,
  output logic [15:0] left_o,
  output logic [15:0] right_o,
  output logic        fin_o
);

  function automatic logic signed [16:0] sample_ext(logic [15:0] raw, logic fmt);
    logic signed [16:0] v;
    if (fmt) begin
      v = {raw[15], raw};
    end else begin
      v = {9'b0, raw[7:0]};
    end
    return v;
  endfunction

  logic [15:0]        silence;
  logic [31:0]        c, n;
  logic signed [9:0]  w_cur, w_nxt;
  logic signed [26:0] p_lc, p_ln, p_rc, p_rn;
  logic signed [26:0] p_lc_q, p_ln_q, p_rc_q, p_rn_q;
  logic               s2_valid_q, s2_fin_q;
  logic signed [27:0] sum_l, sum_r;
  logic [15:0]        left_d, right_d;
  logic               valid_q, fin_q;
  logic [15:0]        left_q, right_q;

  assign silence = sample_format_i ? S16_SILENCE : U8_SILENCE;
  assign c       = req_i.cur_ok ? cur_data_i : {silence, silence};
  assign n       = req_i.nxt_ok ? nxt_data_i : {silence, silence};
  assign w_cur   = {1'b0, 9'd256 - {1'b0, req_i.frac}};
  assign w_nxt   = {2'b0, req_i.frac};

  assign p_lc = sample_ext(c[15:0],  sample_format_i) * w_cur;
  assign p_ln = sample_ext(n[15:0],  sample_format_i) * w_nxt;
  assign p_rc = sample_ext(c[31:16], sample_format_i) * w_cur;
  assign p_rn = sample_ext(n[31:16], sample_format_i) * w_nxt;

  // The shift right by the fraction width floors, so both formats take a slice.
  assign sum_l = {p_lc_q[26], p_lc_q} + {p_ln_q[26], p_ln_q};
  assign sum_r = {p_rc_q[26], p_rc_q} + {p_rn_q[26], p_rn_q};

  always_comb begin
    if (sample_format_i) begin
      left_d  = sum_l[23:8];
      right_d = sum_r[23:8];
    end else begin
      left_d  = {8'b0, sum_l[15:8]};
      right_d = {8'b0, sum_r[15:8]};
    end
    if (!stereo_mode_i) begin
      right_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= req_i.valid;
      valid_q    <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_lc_q   <= p_lc;
      p_ln_q   <= p_ln;
      p_rc_q   <= p_rc;
      p_rn_q   <= p_rn;
      s2_fin_q <= req_i.fin;
      left_q   <= left_d;
      right_q  <= right_d;
      fin_q    <= s2_fin_q;
    end
  end

  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;
  assign fin_o   = fin_q;

endmodule

>>> hw/rtl/linear_interp_sample_resampler.sv
// A produce request's result passes the store read, multiply and output registers.
// Throughput: one request per cycle; loads and starts give no result.
// The store read, the multiply stage and the output register move together
// and all hold while the output register waits to be taken.
// Reset sets position, finished flag, valid flags and configuration to defaults;
// the sample store is not cleared and needs no sweep after reset.
`include "assert_macros.svh"

module linear_interp_sample_resampler import lisr_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: frame_index[15:0], left_sample[31:16], right_sample[47:32]
  input  logic [47:0] s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: left_out[15:0], right_out[31:16]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_FRAMES);

  cfg_t          cfg_q;
  logic          adv;
  logic          fire;
  action_e       action;
  logic          we;
  logic [AW-1:0] waddr, raddr_cur, raddr_nxt;
  logic [31:0]   cur_data, nxt_data;
  rd_req_t       req;
  logic          done;
  logic          out_valid, out_fin;
  logic [15:0]   left_out, right_out;
  logic          prod_fire, start_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= 16'd256;
      cfg_q.frame_count   <= 17'd1;
      cfg_q.loop_enable   <= 1'b0;
      cfg_q.sample_format <= 1'b1;
      cfg_q.stereo_mode   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_SIZE:     cfg_q.step_size     <= cfg_data_i[15:0];
        CFG_FRAME_COUNT:   cfg_q.frame_count   <= cfg_data_i;
        CFG_LOOP_ENABLE:   cfg_q.loop_enable   <= cfg_data_i[0];
        CFG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_data_i[0];
        CFG_STEREO_MODE:   cfg_q.stereo_mode   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves unless a result sits unclaimed at the output.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign fire          = s_axis_tvalid && adv;
  assign action        = action_e'(s_axis_tuser);
  assign prod_fire     = fire && (action == ACT_PRODUCE) && !done;
  assign start_fire    = fire && (action == ACT_START);

  lisr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .AW         (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .fire_i        (fire),
    .action_i      (action),
    .frame_index_i (s_axis_tdata[15:0]),
    .cfg_i         (cfg_q),
    .we_o          (we),
    .waddr_o       (waddr),
    .raddr_cur_o   (raddr_cur),
    .raddr_nxt_o   (raddr_nxt),
    .req_o         (req),
    .done_o        (done)
  );

  lisr_store #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (s_axis_tdata[47:16]),
    .re_i      (adv),
    .raddr_a_i (raddr_cur),
    .raddr_b_i (raddr_nxt),
    .rdata_a_o (cur_data),
    .rdata_b_o (nxt_data)
  );

  lisr_blend u_blend (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .req_i           (req),
    .cur_data_i      (cur_data),
    .nxt_data_i      (nxt_data),
    .sample_format_i (cfg_q.sample_format),
    .stereo_mode_i   (cfg_q.stereo_mode),
    .valid_o         (out_valid),
    .left_o          (left_out),
    .right_o         (right_out),
    .fin_o           (out_fin)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {right_out, left_out};
  assign m_axis_tlast  = out_fin;

  `LISR_ASSERT_NEXT(a_produce_issues, clk_i, rst_ni, prod_fire, req.valid)
  `LISR_ASSERT_NOW(a_fin_sets_done, clk_i, rst_ni, req.valid && req.fin, done)
  `LISR_ASSERT_NEXT(a_start_clears, clk_i, rst_ni, start_fire, !done)

endmodule
